@@ sv/wildcard_star_matcher_assert.svh @@
// ----------------------------------------------------------------------------
// wildcard_star_matcher_assert.svh
// Assertion macros for the wildcard star matcher RTL.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_STAR_MATCHER_ASSERT_SVH
`define WILDCARD_STAR_MATCHER_ASSERT_SVH

// Check a property on every rising edge, quiet while reset is high.
`define WSM_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define WSM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/wsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared types and constants of the wildcard star matcher.
// ----------------------------------------------------------------------------
package wsm_pkg;

   localparam int PATTERN_MAX_DEFAULT = 64;
   localparam int SYM_W               = 8;
   localparam int CMD_W               = 2;
   localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND  = 2'd0,
      CMD_CLEAR   = 2'd1,
      CMD_SUBJECT = 2'd2,
      CMD_FINISH  = 2'd3
   } cmd_type;

   // one-hot strobes for the word being executed this cycle
   typedef struct packed {
      logic append;
      logic clear;
      logic subject;
      logic finish;
   } ctrl_type;

endpackage

@@ sv/wsm_pattern.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_pattern
// Pattern store, length and overflow flag, with per-position compare.
// ----------------------------------------------------------------------------
module wsm_pattern
   import wsm_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT,
   localparam int LEN_W = $clog2(PATTERN_MAX + 1),
   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_type               ctrl,
   input  logic [SYM_W-1:0]       sym,
   output logic [LEN_W-1:0]       pat_len,
   output logic                   overflow,
   output logic [PATTERN_MAX-1:0] star_vec,
   output logic [PATTERN_MAX-1:0] hit_vec,
   output logic [PATTERN_MAX-1:0] star_next
);

   logic [SYM_W-1:0] store_ff [PATTERN_MAX];
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             full;
   logic             wr_en;
   logic             sym_is_star;

   assign full        = (len_ff == LEN_W'(PATTERN_MAX));
   assign wr_en       = ctrl.append && !full;
   assign sym_is_star = (sym == STAR_BYTE);

   always_comb begin
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (ctrl.clear) begin
         len_in = '0;
         ovf_in = 1'b0;
      end else if (ctrl.append) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            len_in = len_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   // store has no reset: entries at or above the length are masked off
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[len_ff[IDX_W-1:0]] <= sym;
      end
   end

   for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_pos
      localparam logic [LEN_W-1:0] POS = LEN_W'(p);
      logic used_cur, used_nxt, is_star, is_new;

      assign used_cur = (POS < len_ff);
      assign used_nxt = (POS < len_in);
      assign is_star  = (store_ff[p] == STAR_BYTE);
      assign is_new   = wr_en && (len_ff == POS);

      assign star_vec[p]  = used_cur && is_star;
      assign hit_vec[p]   = used_cur && !is_star && (store_ff[p] == sym);
      assign star_next[p] = used_nxt && (is_new ? sym_is_star : is_star);
   end

   assign pat_len  = len_ff;
   assign overflow = ovf_ff;

endmodule

@@ sv/wsm_nfa.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_nfa
// Active position vector: shift on subject bytes, close across stars.
// ----------------------------------------------------------------------------
module wsm_nfa
   import wsm_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT,
   localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_type               ctrl,
   input  logic [LEN_W-1:0]       pat_len,
   input  logic [PATTERN_MAX-1:0] star_vec,
   input  logic [PATTERN_MAX-1:0] hit_vec,
   input  logic [PATTERN_MAX-1:0] star_next,
   output logic                   end_active
);

   localparam int VEC_W = PATTERN_MAX + 1;
   localparam logic [VEC_W-1:0] ARMED = VEC_W'(1);

   logic [VEC_W-1:0] active_ff, active_in;
   logic [VEC_W-1:0] raw;
   logic [VEC_W-1:0] prop, gen, carry;
   logic             fire;

   assign fire = ctrl.append || ctrl.clear || ctrl.subject || ctrl.finish;

   always_comb begin
      raw = ARMED;
      if (ctrl.subject) begin
         raw = '0;
         for (int p = 0; p < PATTERN_MAX; p++) begin
            raw[p+1] = raw[p+1] | (active_ff[p] & hit_vec[p]);
            raw[p]   = raw[p]   | (active_ff[p] & star_vec[p]);
         end
      end
   end

   // Star closure as a carry chain: an active star generates, a star propagates.
   // The carry into each bit marks a position reached across stars.
   assign prop      = {1'b0, star_next};
   assign gen       = prop & raw;
   assign carry     = (prop + gen) ^ prop ^ gen;
   assign active_in = raw | carry;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ARMED;
      end else if (fire) begin
         active_ff <= active_in;
      end
   end

   assign end_active = active_ff[pat_len];

endmodule

@@ sv/wildcard_star_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_star_matcher
// Whole-string glob matcher where '*' matches any run of bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on req_*: req_tuser carries the command (append pattern
//   byte, clear pattern, subject byte, end of subject), req_tdata the byte.
//   Load a pattern with append words, stream subject bytes, then send end of
//   subject; one result word comes out on rsp_* with the match bit and the
//   sticky pattern overflow bit. Other commands produce no result word.
// Throughput: one word per cycle, except that an end of subject waits while
//   the previous result is not taken; every pattern position is compared
//   and advanced in parallel, closure across stars is one carry chain.
// Registers: a word is registered at acceptance and executed from the input
//   register; end of subject loads the result register, which drives rsp_*.
// Stall: while a result waits on rsp_tready, the block still takes and
//   executes pattern and subject words; only the next end of subject waits.
// Reset: pattern empty, overflow clear, subject armed at position zero.
//   The pattern store itself is not cleared; only entries below the length
//   are ever used.
// ----------------------------------------------------------------------------
`include "wildcard_star_matcher_assert.svh"

module wildcard_star_matcher
   import wsm_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [1:0] req_tuser,   // [1:0] command
   // response channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   // input register
   logic             in_valid_ff;
   cmd_type          cmd_ff;
   logic [SYM_W-1:0] sym_ff;

   // result register
   logic rsp_valid_ff;
   logic matched_ff;
   logic ovf_out_ff;

   logic     advance;
   ctrl_type ctrl;

   logic [LEN_W-1:0]       pat_len;
   logic                   overflow;
   logic [PATTERN_MAX-1:0] star_vec, hit_vec, star_next;
   logic                   end_active;

   // An end-of-subject word needs room in the result register; others go at once.
   assign advance    = in_valid_ff &&
                       ((cmd_ff != CMD_FINISH) || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff <= cmd_type'(req_tuser);
         sym_ff <= req_tdata;
      end
   end

   // decode the word in the input register into execute strobes
   always_comb begin
      ctrl = '0;
      if (advance) begin
         case (cmd_ff)
            CMD_APPEND:  ctrl.append  = 1'b1;
            CMD_CLEAR:   ctrl.clear   = 1'b1;
            CMD_SUBJECT: ctrl.subject = 1'b1;
            CMD_FINISH:  ctrl.finish  = 1'b1;
            default:     ctrl = '0;
         endcase
      end
   end

   wsm_pattern #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_pattern (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .sym       (sym_ff),
      .pat_len   (pat_len),
      .overflow  (overflow),
      .star_vec  (star_vec),
      .hit_vec   (hit_vec),
      .star_next (star_next)
   );

   wsm_nfa #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_nfa (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .pat_len    (pat_len),
      .star_vec   (star_vec),
      .hit_vec    (hit_vec),
      .star_next  (star_next),
      .end_active (end_active)
   );

   // Load the result on end of subject; drop it once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         matched_ff <= end_active;
         ovf_out_ff <= overflow;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, ovf_out_ff, matched_ff};

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   `WSM_ASSERT_RST(a_rsp_from_finish, clock, reset,
      $rose(rsp_valid_ff) |-> $past(advance && (cmd_ff == CMD_FINISH)),
      "result appeared without an executed end of subject")
   `WSM_ASSERT_RST(a_overflow_when_full, clock, reset,
      overflow |-> (pat_len == LEN_W'(PATTERN_MAX)),
      "overflow flag set while pattern not full")
   `WSM_ASSERT_RST(a_stall_cause, clock, reset,
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready),
      "input stalled without a blocked result")

endmodule

@@ dv/wsm_match_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_match_checker
// Tracks the pattern and the live NFA positions from accepted request words,
// queues the verdict of every end of subject and compares each response word.
// ----------------------------------------------------------------------------
module wsm_match_checker
   import wsm_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [1:0] req_tuser,   // [1:0] command
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [0] matched, [1] pattern_overflow, [7:2] zero
   output int         fail_count,
   output int         pending_results
);

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   logic [SYM_W-1:0]     pattern_mem [PATTERN_MAX];
   int unsigned          pattern_len;
   logic [PATTERN_MAX:0] live_positions;
   logic                 overflow_seen;
   verdict_type          verdict_queue [$];
   int                   failures;

   // empty moves: a live star also makes the position after it live
   function automatic void close_over_stars();
      for (int p = 0; p < pattern_len; p++)
         if (live_positions[p] && pattern_mem[p] == STAR_BYTE)
            live_positions[p+1] = 1'b1;
   endfunction

   function automatic void rearm_subject();
      live_positions    = '0;
      live_positions[0] = 1'b1;
      close_over_stars();
   endfunction

   function automatic void advance_positions(input logic [SYM_W-1:0] sym);
      logic [PATTERN_MAX:0] next_positions;
      next_positions = '0;
      for (int p = 0; p < pattern_len; p++) begin
         if (live_positions[p]) begin
            if (pattern_mem[p] == STAR_BYTE)
               next_positions[p] = 1'b1;
            else if (pattern_mem[p] == sym)
               next_positions[p+1] = 1'b1;
         end
      end
      live_positions = next_positions;
      close_over_stars();
   endfunction

   function automatic void apply_word(input cmd_type cmd, input logic [SYM_W-1:0] sym);
      verdict_type v;
      case (cmd)
         CMD_APPEND: begin
            if (pattern_len < PATTERN_MAX) begin
               pattern_mem[pattern_len] = sym;
               pattern_len++;
            end else begin
               overflow_seen = 1'b1;
            end
            rearm_subject();
         end
         CMD_CLEAR: begin
            pattern_len   = 0;
            overflow_seen = 1'b0;
            rearm_subject();
         end
         CMD_SUBJECT: advance_positions(sym);
         default: begin
            v.matched  = live_positions[pattern_len];
            v.overflow = overflow_seen;
            verdict_queue.push_back(v);
            rearm_subject();
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      verdict_type want;
      if (reset) begin
         pattern_len   = 0;
         overflow_seen = 1'b0;
         rearm_subject();
         verdict_queue.delete();
      end else begin
         // response first: a word leaving now belongs to an older end of subject
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_queue.size() == 0) begin
               $error("unexpected response word %h", rsp_tdata);
               failures++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_tdata[0] !== want.matched) begin
                  $error("matched: expected %0d, got %0d", want.matched, rsp_tdata[0]);
                  failures++;
               end
               if (rsp_tdata[1] !== want.overflow) begin
                  $error("pattern_overflow: expected %0d, got %0d",
                         want.overflow, rsp_tdata[1]);
                  failures++;
               end
               if (rsp_tdata[7:2] !== 6'd0) begin
                  $error("padding: expected 0, got %0d", rsp_tdata[7:2]);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_word(cmd_type'(req_tuser), req_tdata);
      end
      pending_results <= verdict_queue.size();
      fail_count      <= failures;
   end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the wildcard star matcher: directed corner words,
// then random pattern loads and subjects, with idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import wsm_pkg::*;

   localparam int WORD_TARGET  = 1250;   // stop offering new scenarios here
   localparam int QUIET_START  = 1100;   // no idling from here on
   localparam int LONG_HOLD    = 200;    // response hold-off that fills the block
   localparam int DRAIN_CYCLES = 8;      // margin after the last result

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;      // [7:0] symbol
   logic [1:0] req_tuser  = CMD_CLEAR; // [1:0] command
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;              // [0] matched, [1] pattern_overflow, [7:2] zero

   int         fail_count;
   int         pending_results;

   // stimulus state; quiet and the stall flags are shared with the response driver
   bit         quiet         = 1'b0;
   bit         stall_request = 1'b0;
   bit         stall_served  = 1'b0;
   int         words_sent    = 0;
   bit         overflow_done = 1'b0;
   bit         pressure_done = 1'b0;

   // stimulus-side copy of the stored pattern, used only to build subjects
   logic [7:0] pattern_copy [$];

   always #6 clock = ~clock;

   wildcard_star_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   wsm_match_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // Bias toward a small alphabet so that literal bytes line up and subjects
   // actually match; keep the extremes and the star in the mix.
   function automatic logic [7:0] pick_symbol();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'h61;
         3, 4:    return 8'h62;
         5:       return STAR_BYTE;
         6:       return 8'h00;
         7:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one word and hold it until the block takes it. A random idle burst
   // may come first; valid drops in the step of the previous acceptance and
   // rises again only after the burst.
   task automatic send_word(input cmd_type cmd, input logic [7:0] sym);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= sym;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      // mirror what the block keeps: bytes past capacity are dropped
      if (cmd == CMD_APPEND && pattern_copy.size() < PATTERN_MAX_DEFAULT)
         pattern_copy.push_back(sym);
      if (cmd == CMD_CLEAR)
         pattern_copy.delete();
   endtask

   // Drop valid and hold until every queued verdict has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic load_pattern(input int len);
      send_word(CMD_CLEAR, 8'($urandom_range(0, 255)));
      repeat (len)
         send_word(CMD_APPEND, ($urandom_range(0, 3) == 0) ? STAR_BYTE : pick_symbol());
   endtask

   // Build one subject and close it with end of subject.
   //   faithful: literal bytes copied, each star expanded to 0..3 bytes
   //   mutated:  faithful, then one byte replaced, dropped or inserted
   //   loose:    random bytes of random length
   task automatic run_subject(input int flavor);
      logic [7:0] subject_bytes [$];
      int         idx;
      if (flavor == 2) begin
         repeat ($urandom_range(0, 10)) subject_bytes.push_back(pick_symbol());
      end else begin
         foreach (pattern_copy[i]) begin
            if (pattern_copy[i] == STAR_BYTE)
               repeat ($urandom_range(0, 3)) subject_bytes.push_back(pick_symbol());
            else
               subject_bytes.push_back(pattern_copy[i]);
         end
         if (flavor == 1 && subject_bytes.size() > 0) begin
            idx = $urandom_range(0, subject_bytes.size() - 1);
            case ($urandom_range(0, 2))
               0:       subject_bytes[idx] = pick_symbol();
               1:       subject_bytes.delete(idx);
               default: subject_bytes.insert(idx, pick_symbol());
            endcase
         end
      end
      foreach (subject_bytes[i])
         send_word(CMD_SUBJECT, subject_bytes[i]);
      send_word(CMD_FINISH, 8'($urandom_range(0, 255)));
   endtask

   // Response side: random stall bursts, a long hold-off on request, and a
   // steady ready once the run goes quiet. One assignment per step.
   initial begin
      forever begin
         if (stall_request && !stall_served) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            stall_served = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---- directed corners ----
      // empty pattern against the empty subject: match
      send_word(CMD_FINISH, 8'hFF);
      // empty pattern against a one-byte subject (zero byte): no match
      send_word(CMD_SUBJECT, 8'h00);
      send_word(CMD_FINISH, 8'h00);
      // lone star matches the empty subject
      send_word(CMD_APPEND, STAR_BYTE);
      send_word(CMD_FINISH, 8'h00);
      // lone star swallows any run, star in the subject is a plain byte
      send_word(CMD_SUBJECT, 8'hFF);
      send_word(CMD_SUBJECT, STAR_BYTE);
      send_word(CMD_FINISH, 8'hFF);
      // clear the pattern, then match literal zero and all-ones bytes
      send_word(CMD_CLEAR, 8'hFF);
      send_word(CMD_APPEND, 8'h00);
      send_word(CMD_APPEND, 8'hFF);
      send_word(CMD_SUBJECT, 8'h00);
      send_word(CMD_SUBJECT, 8'hFF);
      send_word(CMD_FINISH, 8'h00);
      // append mid-subject: the byte already taken is forgotten
      send_word(CMD_SUBJECT, 8'h00);
      send_word(CMD_APPEND, STAR_BYTE);
      send_word(CMD_SUBJECT, 8'h00);
      send_word(CMD_SUBJECT, 8'hFF);
      send_word(CMD_SUBJECT, 8'h01);
      send_word(CMD_FINISH, 8'hFF);
      // literal pattern byte against a star in the subject: no match
      send_word(CMD_CLEAR, 8'h00);
      send_word(CMD_APPEND, 8'h61);
      send_word(CMD_SUBJECT, STAR_BYTE);
      send_word(CMD_FINISH, 8'h00);

      // pause the sender until every verdict so far is back
      drain_results();

      // ---- random scenarios ----
      while (words_sent < WORD_TARGET) begin
         if (words_sent >= QUIET_START)
            quiet = 1'b1;

         if (!overflow_done && words_sent >= 300) begin
            // overrun the store: extra appends drop, the sticky flag rises
            overflow_done = 1'b1;
            load_pattern(PATTERN_MAX_DEFAULT + 5);
            repeat (3) run_subject($urandom_range(0, 2));
         end else if (!pressure_done && words_sent >= 550) begin
            // hold responses back while ends of subject keep coming, so the
            // block fills up and stalls the request side
            pressure_done = 1'b1;
            drain_results();
            load_pattern(3);
            stall_request = 1'b1;
            repeat (12) run_subject(0);
         end else begin
            case ($urandom_range(0, 19))
               0:             load_pattern($urandom_range(56, 72));
               1, 2, 3, 4, 5: load_pattern($urandom_range(0, 8));
               default: ;     // keep the current pattern
            endcase
            // noise: any command, any byte, also between subject bytes
            if ($urandom_range(0, 7) == 0)
               send_word(cmd_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 5))
                  0, 1, 2: run_subject(0);
                  3, 4:    run_subject(1);
                  default: run_subject(2);
               endcase
            end
         end
      end

      // ---- wind down ----
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/wsm_pkg.sv
sv/wsm_pattern.sv
sv/wsm_nfa.sv
sv/wildcard_star_matcher.sv
dv/wsm_match_checker.sv
dv/testbench.sv
